// ===== hdl/fnpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fnpa_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CNT_W      = 9;
    localparam int NB_W       = 13;
    localparam int PN_W       = 9;
    localparam int OFF_W      = 21;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LINK_W-1:0] LIST_END   = LINK_W'(POOL_DEPTH);
    localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [NB_W-1:0]   NB_MAX     = NB_W'(4096);
    localparam logic [NB_W-1:0]   NB_RESET   = NB_W'(64);
    localparam logic [PN_W-1:0]   PN_RESET   = PN_W'(256);
    localparam logic [PN_W-1:0]   PN_MAX     = PN_W'(POOL_DEPTH);

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_NODES = 1'd1;

    typedef struct packed {
        logic load;   // request accepted: update state and result register
        logic pop;    // pop state after a successful allocate: head takes the fetched link
    } ctrl_cmd_t;

    typedef struct packed {
        logic alloc_hit;  // current input is an allocate that will succeed
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fixed_node_pool_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size node pool allocator with a linked free list.
// Request channel (in_valid/in_ready): op selects allocate or release,
// node_index names the node to release. Response channel (out_valid/
// out_ready): status, given_index, byte_offset, used_count, one per request.
// Config port: cfg_we/cfg_index/cfg_data write node_bytes (0) or pool_nodes
// (1); writing pool_nodes relinks the whole pool and clears the use count.
// Write config only while idle.
// The response is registered at the edge that accepts the request, so it
// shows in the next cycle. A successful allocate then passes through a pop
// state, because the new head comes from a registered read of the link
// memory; a release or a failed allocate (empty pool) has no pop state.
// Reset links nodes 0..255 in order with node 0 at the head; per-entry
// valid bits stand in for the init walk, so there is no clearing pass.
// A new request is taken while the last response waits, but only if the
// response register is being drained that cycle; a stalled receiver holds
// the response and blocks further requests.

module fixed_node_pool_allocator (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [fnpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [fnpa_pkg::CFG_W-1:0]        cfg_data,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire                               op,
    input  wire  [fnpa_pkg::IDX_W-1:0]        node_index,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              status,
    output logic [fnpa_pkg::IDX_W-1:0]        given_index,
    output logic [fnpa_pkg::OFF_W-1:0]        byte_offset,
    output logic [fnpa_pkg::CNT_W-1:0]        used_count
);
    import fnpa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    fnpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fnpa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .node_index  (node_index),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .given_index (given_index),
        .byte_offset (byte_offset),
        .used_count  (used_count)
    );

endmodule

`default_nettype wire

// ===== hdl/fnpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnpa_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  fnpa_pkg::dp_stat_t   stat,
    output fnpa_pkg::ctrl_cmd_t  cmd
);
    import fnpa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load = accept;
        cmd.pop  = (state_reg == S_POP);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.alloc_hit)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fnpa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnpa_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [fnpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [fnpa_pkg::CFG_W-1:0]           cfg_data,
    input  wire                                  op,
    input  wire  [fnpa_pkg::IDX_W-1:0]           node_index,
    input  fnpa_pkg::ctrl_cmd_t                  cmd,
    output fnpa_pkg::dp_stat_t                   stat,
    output logic                                 status,
    output logic [fnpa_pkg::IDX_W-1:0]           given_index,
    output logic [fnpa_pkg::OFF_W-1:0]           byte_offset,
    output logic [fnpa_pkg::CNT_W-1:0]           used_count
);
    import fnpa_pkg::*;

    logic [NB_W-1:0]       node_bytes_reg;
    logic [PN_W-1:0]       pool_nodes_reg;
    logic [LINK_W-1:0]     head_reg;
    logic [LINK_W-1:0]     head_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [POOL_DEPTH-1:0] link_valid_reg;

    logic [LINK_W-1:0]     link_mem [0:POOL_DEPTH-1];
    logic [LINK_W-1:0]     rd_link_reg;
    logic                  rd_valid_reg;
    logic [LINK_W-1:0]     rd_init_reg;

    logic                  status_reg;
    logic [IDX_W-1:0]      given_reg;
    logic [OFF_W-1:0]      offset_reg;
    logic [CNT_W-1:0]      used_reg;

    logic                  pool_wr;
    logic [LINK_W-1:0]     active_n;
    logic [NB_W-1:0]       size_sat;
    logic [NB_W-1:0]       padded;
    logic [IDX_W-1:0]      head_idx;
    logic                  empty;
    logic [LINK_W-1:0]     head_plus;
    logic [LINK_W-1:0]     init_link;
    logic                  rel_ok;
    logic                  do_alloc;
    logic                  do_release;
    logic [OFF_W-1:0]      product;

    assign pool_wr = cfg_we && (cfg_index == REG_POOL_NODES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_bytes_reg <= NB_RESET;
            pool_nodes_reg <= PN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_BYTES: node_bytes_reg <= cfg_data[NB_W-1:0];
                REG_POOL_NODES: pool_nodes_reg <= cfg_data[PN_W-1:0];
                default:        node_bytes_reg <= node_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        if (pool_nodes_reg == '0)
        begin
            active_n = LINK_W'(1);
        end
        else if (pool_nodes_reg > PN_MAX)
        begin
            active_n = LIST_END;
        end
        else
        begin
            active_n = LINK_W'(pool_nodes_reg);
        end

        if (node_bytes_reg == '0)
        begin
            size_sat = NB_W'(1);
        end
        else if (node_bytes_reg > NB_MAX)
        begin
            size_sat = NB_MAX;
        end
        else
        begin
            size_sat = node_bytes_reg;
        end
    end

    // round up to a multiple of 8
    assign padded = (size_sat + NB_W'(7)) & ~NB_W'(7);

    assign head_idx   = head_reg[IDX_W-1:0];
    assign empty      = head_reg[IDX_W];
    assign head_plus  = {1'b0, head_idx} + LINK_W'(1);
    // link an entry holds until first written since the last init walk
    assign init_link  = (head_plus < active_n) ? head_plus : LIST_END;
    assign rel_ok     = ({1'b0, node_index} < active_n);
    assign do_alloc   = cmd.load && (op == OP_ALLOC) && !empty;
    assign do_release = cmd.load && (op == OP_RELEASE) && rel_ok;
    assign product    = OFF_W'(head_idx) * OFF_W'(padded);

    assign stat.alloc_hit = (op == OP_ALLOC) && !empty;

    always_ff @(posedge clk)
    begin
        if (do_release)
        begin
            link_mem[node_index] <= head_reg;
        end
        if (cmd.load)
        begin
            rd_link_reg <= link_mem[head_idx];
            rd_valid_reg <= link_valid_reg[head_idx];
            rd_init_reg <= init_link;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
        end
        else if (pool_wr)
        begin
            link_valid_reg <= '0;
        end
        else if (do_release)
        begin
            link_valid_reg[node_index] <= 1'b1;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pool_wr)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (cmd.pop)
        begin
            head_next = rd_valid_reg ? rd_link_reg : rd_init_reg;
        end
        else if (do_alloc)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (do_release)
        begin
            head_next = {1'b0, node_index};
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= (op == OP_ALLOC) && empty;
            given_reg  <= do_alloc ? head_idx : '0;
            offset_reg <= do_alloc ? product : '0;
            used_reg   <= count_next;
        end
    end

    assign status      = status_reg;
    assign given_index = given_reg;
    assign byte_offset = offset_reg;
    assign used_count  = used_reg;

endmodule

`default_nettype wire

// ===== hdl/fnpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnpa_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_ready,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire                               status,
    input wire [fnpa_pkg::IDX_W-1:0]         given_index,
    input wire [fnpa_pkg::OFF_W-1:0]         byte_offset,
    input wire [fnpa_pkg::CNT_W-1:0]         used_count
);

    // stalled response holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(given_index) && $stable(byte_offset) && $stable(used_count))
        else $error("response changed while stalled");

    // every accepted request is answered on the next cycle
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no response after accepted request");

    // an empty-pool response carries no node
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> given_index == '0 && byte_offset == '0)
        else $error("empty response carries a node");

    // offsets stay 8-byte aligned
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_offset[2:0] == 3'd0)
        else $error("unaligned byte offset");

endmodule

bind fixed_node_pool_allocator fnpa_checker u_fnpa_checker (.*);

`default_nettype wire

// ===== tb/fixed_node_pool_allocator_test.sv =====
`timescale 1ns / 1ps

module fixed_node_pool_allocator_test;
    import fnpa_pkg::*;

    localparam int ALIGN       = 8;
    localparam int SLOT_MAX    = 4096;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic              status;
        logic [IDX_W-1:0]  given;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
    } pool_reply_t;

    typedef enum logic [1:0] {STEP_REQ, STEP_SET_BYTES, STEP_SET_POOL} step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        logic              op;
        logic [CFG_W-1:0]  arg;
        logic              chk;
        pool_reply_t       want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = OP_ALLOC;
    logic [IDX_W-1:0]      node_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  status;
    logic [IDX_W-1:0]      given_index;
    logic [OFF_W-1:0]      byte_offset;
    logic [CNT_W-1:0]      used_count;

    fixed_node_pool_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .node_index  (node_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .given_index (given_index),
        .byte_offset (byte_offset),
        .used_count  (used_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // free-list shadow
    logic [LINK_W-1:0] link_mem [POOL_DEPTH];
    logic [LINK_W-1:0] free_head;
    logic [CNT_W-1:0]  live_count;
    logic [NB_W-1:0]   cfg_bytes;
    logic [PN_W-1:0]   cfg_pool;

    pool_reply_t       pending_resp [$];
    logic [IDX_W-1:0]  held_nodes [$];

    int  fault_count = 0;
    int  n_req = 0;
    int  n_grant = 0;
    int  n_empty = 0;
    int  n_cfg = 0;
    int  peak_count = 0;
    bit  hold_out = 1'b0;
    bit  calm = 1'b0;

    function automatic int pool_span();
        int n;
        n = int'(cfg_pool);
        if (n < 1) n = 1;
        if (n > POOL_DEPTH) n = POOL_DEPTH;
        return n;
    endfunction

    function automatic int slot_bytes();
        int s;
        s = int'(cfg_bytes);
        if (s < 1) s = 1;
        if (s > SLOT_MAX) s = SLOT_MAX;
        return (s + ALIGN - 1) & ~(ALIGN - 1);
    endfunction

    function automatic void relink_pool();
        int n;
        n = pool_span();
        for (int i = 0; i < POOL_DEPTH; i++)
            link_mem[i] = (i + 1 < n) ? LINK_W'(i + 1) : LIST_END;
        free_head  = '0;
        live_count = '0;
    endfunction

    function automatic pool_reply_t serve_request(logic req_op, logic [IDX_W-1:0] idx);
        pool_reply_t rep;
        rep = '0;
        if (req_op == OP_ALLOC)
        begin
            if (free_head >= LIST_END)
                rep.status = 1'b1;
            else
            begin
                rep.given  = free_head[IDX_W-1:0];
                rep.offset = OFF_W'(int'(free_head) * slot_bytes());
                free_head  = link_mem[free_head[IDX_W-1:0]];
                if (live_count != COUNT_MAX) live_count = live_count + 1'b1;
            end
        end
        else if (int'(idx) < pool_span())
        begin
            link_mem[idx] = free_head;
            free_head     = {1'b0, idx};
            if (live_count != 0) live_count = live_count - 1'b1;
        end
        rep.count = live_count;
        return rep;
    endfunction

    function automatic step_t ask(logic o, int a);
        step_t s;
        s = '0;
        s.kind = STEP_REQ;
        s.op   = o;
        s.arg  = CFG_W'(a);
        return s;
    endfunction

    function automatic step_t ask_chk(logic o, int a, int st, int gi, int off, int cnt);
        step_t s;
        s = ask(o, a);
        s.chk         = 1'b1;
        s.want.status = st[0];
        s.want.given  = IDX_W'(gi);
        s.want.offset = OFF_W'(off);
        s.want.count  = CNT_W'(cnt);
        return s;
    endfunction

    function automatic step_t setreg(step_kind_t k, int v);
        step_t s;
        s = '0;
        s.kind = k;
        s.arg  = CFG_W'(v);
        return s;
    endfunction

    task automatic flag_error(string what);
        $display("ERROR @%0t: %s", $time, what);
        fault_count++;
    endtask

    // drop valid and wait for the reply queue to drain; a grant may still
    // be fetching its link when the last reply shows, hence the extra cycles
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_NODE_BYTES)
            cfg_bytes = data[NB_W-1:0];
        else
        begin
            cfg_pool = data[PN_W-1:0];
            relink_pool();
            held_nodes.delete();
        end
        n_cfg++;
        @(posedge clk);
    endtask

    task automatic push_req(input logic req_op, input logic [IDX_W-1:0] idx,
                            input logic typed, input pool_reply_t typed_reply,
                            output pool_reply_t rep);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= req_op;
        node_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        rep = serve_request(req_op, idx);
        pending_resp.push_back(typed ? typed_reply : rep);
        n_req++;
        if (req_op == OP_ALLOC)
        begin
            if (rep.status) n_empty++;
            else n_grant++;
        end
        if (int'(rep.count) > peak_count) peak_count = int'(rep.count);
    endtask

    always @(posedge clk)
    begin : reply_check
        pool_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_resp.size() == 0)
                flag_error("reply transfer with nothing outstanding");
            else
            begin
                want = pending_resp.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %0d, want %0d", status, want.status));
                if (given_index !== want.given)
                    flag_error($sformatf("given_index %0d, want %0d",
                                         given_index, want.given));
                if (byte_offset !== want.offset)
                    flag_error($sformatf("byte_offset %0d, want %0d",
                                         byte_offset, want.offset));
                if (used_count !== want.count)
                    flag_error($sformatf("used_count %0d, want %0d",
                                         used_count, want.count));
            end
        end
    end

    // reply side: random stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = (r < 17) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                out_ready <= (r >= 20);
            end
        end
    end

    initial
    begin
        #2400000;
        $display("fixed_node_pool_allocator verification failed");
        $finish;
    end

    initial
    begin
        step_t             plan [$];
        pool_reply_t       rep;
        logic [IDX_W-1:0]  idx;
        int                r;
        int                k;

        cfg_bytes = NB_RESET;
        cfg_pool  = PN_RESET;
        relink_pool();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   0,     0, 1));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   1,    64, 2));
        plan.push_back(ask_chk(OP_RELEASE,   0, 0,   0,     0, 1));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   0,     0, 2));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   2,   128, 3));
        plan.push_back(ask_chk(OP_RELEASE, 255, 0,   0,     0, 2));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0, 255, 16320, 3));
        plan.push_back(setreg(STEP_SET_BYTES, 4096));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   3, 12288, 4));
        plan.push_back(setreg(STEP_SET_BYTES, 0));      // saturates up to 1, pads to 8
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   4,    32, 5));
        plan.push_back(setreg(STEP_SET_BYTES, 8191));   // saturates down to 4096
        plan.push_back(ask_chk(OP_RELEASE,   4, 0,   0,     0, 4));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   4, 16384, 5));
        plan.push_back(ask(OP_RELEASE, 170));
        plan.push_back(ask(OP_ALLOC, 85));
        plan.push_back(setreg(STEP_SET_POOL, 2));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   0,     0, 1));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   1,  4096, 2));
        plan.push_back(ask_chk(OP_ALLOC,     0, 1,   0,     0, 2));  // list empty
        plan.push_back(ask_chk(OP_RELEASE,   2, 0,   0,     0, 2));  // outside pool
        plan.push_back(ask_chk(OP_RELEASE,   1, 0,   0,     0, 1));
        plan.push_back(setreg(STEP_SET_BYTES, 13));
        plan.push_back(setreg(STEP_SET_POOL, 0));       // saturates up to one node
        plan.push_back(ask_chk(OP_RELEASE,   0, 0,   0,     0, 0));  // nothing in use
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   0,     0, 1));
        plan.push_back(ask_chk(OP_ALLOC,     0, 0,   0,     0, 2));  // node 0 links to itself
        plan.push_back(ask(OP_ALLOC, 255));
        plan.push_back(setreg(STEP_SET_POOL, 511));     // saturates down to full depth
        plan.push_back(ask(OP_ALLOC, 0));

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REQ)
                push_req(plan[i].op, plan[i].arg[IDX_W-1:0], plan[i].chk, plan[i].want, rep);
            else
            begin
                settle();
                write_reg(plan[i].kind == STEP_SET_BYTES ? REG_NODE_BYTES : REG_POOL_NODES,
                          plan[i].arg);
            end
        end

        // a self-linked head keeps grants coming until the count saturates
        settle();
        write_reg(REG_POOL_NODES, CFG_W'(1));
        push_req(OP_RELEASE, '0, 1'b0, '0, rep);
        for (int n = 0; n < 515; n++)
            push_req(OP_ALLOC, IDX_W'($urandom), 1'b0, '0, rep);
        repeat (3) push_req(OP_RELEASE, '0, 1'b0, '0, rep);

        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            calm = (ph == 4);
            r = $urandom_range(0, 99);
            if (ph == 0)
                write_reg(REG_NODE_BYTES, CFG_W'(SLOT_MAX));
            else if (ph == 1)
                write_reg(REG_NODE_BYTES, CFG_W'(1));
            else
                write_reg(REG_NODE_BYTES, (r < 25) ? CFG_W'($urandom)
                                                   : CFG_W'($urandom_range(1, SLOT_MAX)));
            r = $urandom_range(0, 99);
            if (ph == 0)
                write_reg(REG_POOL_NODES, CFG_W'(POOL_DEPTH));
            else if (ph == 1)
                write_reg(REG_POOL_NODES, CFG_W'(1));
            else if (r < 55)
                write_reg(REG_POOL_NODES, CFG_W'($urandom_range(1, 8)));
            else if (r < 70)
                write_reg(REG_POOL_NODES, CFG_W'(POOL_DEPTH));
            else
                write_reg(REG_POOL_NODES, CFG_W'($urandom));
            if (ph == 2) hold_out = 1'b1;

            for (int n = 0; n < 110; n++)
            begin
                if (ph == 5 && n == 55) settle();
                r = $urandom_range(0, 99);
                if (held_nodes.size() == 0 || r < 50)
                begin
                    push_req(OP_ALLOC, IDX_W'($urandom), 1'b0, '0, rep);
                    if (!rep.status) held_nodes.push_back(rep.given);
                end
                else if (r < 88)
                begin
                    k   = $urandom_range(0, held_nodes.size() - 1);
                    idx = held_nodes[k];
                    held_nodes.delete(k);
                    push_req(OP_RELEASE, idx, 1'b0, '0, rep);
                end
                else
                    push_req(OP_RELEASE, IDX_W'($urandom), 1'b0, '0, rep);
            end
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (pending_resp.size() != 0)
            flag_error($sformatf("%0d replies never arrived", pending_resp.size()));

        $display("Covered %0d requests: %0d grants, %0d empty-pool replies, %0d register writes",
                 n_req, n_grant, n_empty, n_cfg);
        $display("Live count peaked at %0d; reply side held off %0d cycles once",
                 peak_count, HOLD_CYCLES);
        if (fault_count == 0)
            $display("fixed_node_pool_allocator verification clean");
        else
            $display("fixed_node_pool_allocator verification failed");
        $finish;
    end

endmodule
